// ===== rtl/base64_stream_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Shorthand for clocked assertions with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Condition must hold in the same cycle whenever the trigger is true
`define B64SD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must never be true
`define B64SD_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ===== rtl/b64sd_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Shared types, codes and the character map of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64sd_pkg;

	localparam int DEF_COUNT_WIDTH = 16;
	localparam int DEF_QUEUE_DEPTH = 4;
	localparam int CAP_W           = 16;
	localparam int OUT_COUNT_W     = 16;

	// Internal sextet codes: 0..63 data, plus pad and bad character
	localparam logic [6:0] SEXTET_PAD   = 7'd64;
	localparam logic [6:0] SEXTET_BAD   = 7'd65;
	localparam logic [6:0] SEXTET_PLUS  = 7'd62;
	localparam logic [6:0] SEXTET_SLASH = 7'd63;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_CHAR = 2'd1,
		STATUS_BAD_END  = 2'd2,
		STATUS_NO_ROOM  = 2'd3
	} status_t;

	// One queue entry: all results caused by one accepted character
	typedef struct packed {
		logic [1:0]      n_bytes;
		logic [2:0][7:0] bytes;
		logic            has_end;
		status_t         status;
		logic [OUT_COUNT_W-1:0] byte_count;
	} b64sd_entry_t;

	// Map one character to its sextet code
	function automatic logic [6:0] map_char(input logic [7:0] c);
		logic [6:0] s;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s = 7'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s = 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			s = SEXTET_PLUS;
		end else if (c == 8'h2F) begin
			s = SEXTET_SLASH;
		end else if (c == 8'h3D) begin
			s = SEXTET_PAD;
		end else begin
			s = SEXTET_BAD;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/b64sd_front.sv =====
// ----------------------------------------------------------------------------
// Base64 stream decoder front end
// Classifies each character, gathers groups, decodes them against the
// capacity limit and builds a queue entry for each character that yields bytes or ends the message.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sd_front import b64sd_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire logic [7:0]       character,
	input  wire logic             final_char,
	input  wire logic [CAP_W-1:0] capacity,
	output logic                  push,
	output b64sd_entry_t          entry
);

	localparam int CMP_W = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 1;

	logic [6:0]             hold_q [3];
	logic [1:0]             pos_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   halted_q;
	status_t                status_q;

	logic [6:0]             hold_d [3];
	logic [1:0]             pos_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic                   halted_d;
	status_t                status_d;

	logic [6:0]             sext;
	logic [6:0]             g0, g1, g2, g3;
	logic                   closes;
	logic [1:0]             want;
	logic                   pad_halt;
	logic                   bad_end;
	logic [7:0]             b0, b1, b2;
	logic [COUNT_WIDTH-1:0] base1, base2;
	logic [2:0]             room;
	logic [1:0]             n_ok;
	logic [1:0]             n_emit;
	logic                   short;
	logic [1:0]             n_bytes;

	// Classify and assemble the group with the new sextet in place
	always_comb begin
		sext   = map_char(character);
		g0     = (pos_q == 2'd0) ? sext : hold_q[0];
		g1     = (pos_q == 2'd1) ? sext : hold_q[1];
		g2     = (pos_q == 2'd2) ? sext : hold_q[2];
		g3     = (pos_q == 2'd3) ? sext : SEXTET_PAD;
		closes = (pos_q == 2'd3) || final_char;
	end

	// Decode pad placement and byte values
	always_comb begin
		want     = 2'd3;
		pad_halt = 1'b0;
		bad_end  = 1'b0;
		if (g0 == SEXTET_PAD) begin
			want     = 2'd0;
			pad_halt = 1'b1;
		end else if (g1 == SEXTET_PAD) begin
			want     = 2'd1;
			pad_halt = 1'b1;
		end else if (g2 == SEXTET_PAD) begin
			want     = 2'd1;
			pad_halt = 1'b1;
			bad_end  = (g3 != SEXTET_PAD);
		end else if (g3 == SEXTET_PAD) begin
			want     = 2'd2;
		end
		b0 = (g1 == SEXTET_PAD) ? {g0[5:0], 2'b00} : {g0[5:0], g1[5:4]};
		b1 = {g1[3:0], g2[5:2]};
		b2 = {g2[1:0], g3[5:0]};
	end

	// Check room for each byte against the running count
	always_comb begin
		base1   = count_q + COUNT_WIDTH'(1);
		base2   = count_q + COUNT_WIDTH'(2);
		room[0] = (CMP_W'(count_q) + CMP_W'(1)) <= CMP_W'(capacity);
		room[1] = (CMP_W'(base1) + CMP_W'(1)) <= CMP_W'(capacity);
		room[2] = (CMP_W'(base2) + CMP_W'(1)) <= CMP_W'(capacity);
		if (!room[0]) begin
			n_ok = 2'd0;
		end else if (!room[1]) begin
			n_ok = 2'd1;
		end else if (!room[2]) begin
			n_ok = 2'd2;
		end else begin
			n_ok = 2'd3;
		end
		n_emit = (want < n_ok) ? want : n_ok;
		short  = (n_emit < want);
	end

	// Advance the message state and build the entry
	always_comb begin
		hold_d   = hold_q;
		pos_d    = pos_q;
		count_d  = count_q;
		halted_d = halted_q;
		status_d = status_q;
		n_bytes  = 2'd0;
		if (!halted_q) begin
			if (sext == SEXTET_BAD) begin
				status_d = STATUS_BAD_CHAR;
				halted_d = 1'b1;
			end else if (closes) begin
				n_bytes = n_emit;
				count_d = count_q + COUNT_WIDTH'(n_emit);
				if (short) begin
					status_d = STATUS_NO_ROOM;
					halted_d = 1'b1;
				end else if (pad_halt) begin
					halted_d = 1'b1;
					if (bad_end) begin
						status_d = STATUS_BAD_END;
					end
				end
				hold_d[0] = SEXTET_PAD;
				hold_d[1] = SEXTET_PAD;
				hold_d[2] = SEXTET_PAD;
				pos_d     = 2'd0;
			end else begin
				hold_d[pos_q] = sext;
				pos_d         = pos_q + 2'd1;
			end
		end

		entry.n_bytes    = n_bytes;
		entry.bytes[0]   = b0;
		entry.bytes[1]   = b1;
		entry.bytes[2]   = b2;
		entry.has_end    = final_char;
		entry.status     = status_d;
		entry.byte_count = OUT_COUNT_W'(count_d);
		push             = take && ((n_bytes != 2'd0) || final_char);

		// Drop the per-message state after the end report
		if (final_char) begin
			hold_d[0] = SEXTET_PAD;
			hold_d[1] = SEXTET_PAD;
			hold_d[2] = SEXTET_PAD;
			pos_d     = 2'd0;
			count_d   = '0;
			halted_d  = 1'b0;
			status_d  = STATUS_OK;
		end
	end

	// Hold state between transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q[0] <= SEXTET_PAD;
			hold_q[1] <= SEXTET_PAD;
			hold_q[2] <= SEXTET_PAD;
			pos_q     <= 2'd0;
			count_q   <= '0;
			halted_q  <= 1'b0;
			status_q  <= STATUS_OK;
		end else if (take) begin
			hold_q    <= hold_d;
			pos_q     <= pos_d;
			count_q   <= count_d;
			halted_q  <= halted_d;
			status_q  <= status_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/b64sd_queue.sv =====
// ----------------------------------------------------------------------------
// Base64 stream decoder entry queue
// Small FIFO that decouples the front end from the result serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sd_queue import b64sd_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire b64sd_entry_t  push_entry,
	input  wire logic          pop,
	output b64sd_entry_t       head_entry,
	output logic               full,
	output logic               empty
);

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	b64sd_entry_t      mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign full       = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign empty      = (fill_q == '0);
	assign head_entry = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/b64sd_back.sv =====
// ----------------------------------------------------------------------------
// Base64 stream decoder back end
// Walks the head entry and presents its results one transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sd_back import b64sd_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire b64sd_entry_t            head_entry,
	input  wire logic                    empty,
	output logic                         pop,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         kind,
	output logic [7:0]                   data_byte,
	output logic [1:0]                   status,
	output logic [OUT_COUNT_W-1:0]       byte_count,
	output logic                         run_last
);

	logic [1:0] idx_q;
	logic [2:0] total;
	logic       is_data;

	// Select the current result of the head entry
	always_comb begin
		total     = {1'b0, head_entry.n_bytes} + {2'b00, head_entry.has_end};
		is_data   = (idx_q < head_entry.n_bytes);
		run_last  = (({1'b0, idx_q} + 3'd1) == total);
		out_valid = !empty;
		pop       = out_valid && out_ready && run_last;
		kind      = is_data ? KIND_DATA : KIND_END;
		data_byte = 8'd0;
		if (is_data) begin
			case (idx_q)
				2'd0:    data_byte = head_entry.bytes[0];
				2'd1:    data_byte = head_entry.bytes[1];
				2'd2:    data_byte = head_entry.bytes[2];
				default: data_byte = 8'd0;
			endcase
		end
		status     = is_data ? 2'(STATUS_OK) : 2'(head_entry.status);
		byte_count = is_data ? '0 : head_entry.byte_count;
	end

	// Step through results; restart on each new entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (out_valid && out_ready) begin
			idx_q <= run_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// Base64 stream decoder: one character accepted per cycle while the queue has room.
// The first result appears in the cycle after its transfer when the queue is empty.
// Throughput: one result per cycle out while out_ready is high; input stalls only when the queue is full.
// Reset: asynchronous, clears message state and queue; capacity returns to 65535.
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder import b64sd_pkg::*; #(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CAP_W-1:0]       cfg_wr_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [7:0]             character,
	input  wire logic                   final_char,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        kind,
	output logic [7:0]                  data_byte,
	output logic [1:0]                  status,
	output logic [OUT_COUNT_W-1:0]      byte_count,
	output logic                        run_last
);

	logic [CAP_W-1:0] capacity_q;
	logic             take;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	b64sd_entry_t     push_entry;
	b64sd_entry_t     head_entry;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= {CAP_W{1'b1}};
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	b64sd_front #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.character  (character),
		.final_char (final_char),
		.capacity   (capacity_q),
		.push       (q_push),
		.entry      (push_entry)
	);

	b64sd_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.head_entry (head_entry),
		.full       (q_full),
		.empty      (q_empty)
	);

	b64sd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_entry (head_entry),
		.empty      (q_empty),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.data_byte  (data_byte),
		.status     (status),
		.byte_count (byte_count),
		.run_last   (run_last)
	);

	// End report always closes the results of its character
	`B64SD_ASSERT_IMP(a_end_is_last, out_valid && kind == KIND_END, run_last, "end report not last")
	// Data results carry no status or count
	`B64SD_ASSERT_IMP(a_data_clean, out_valid && kind == KIND_DATA, status == 2'(STATUS_OK) && byte_count == '0, "data result has status or count")
	// Front must never push into a full queue
	`B64SD_ASSERT_NEVER(a_no_overflow, q_push && q_full, "queue overflow")

endmodule

`default_nettype wire
